// ----- sv/pcf_pkg.sv -----
// Shared types, constants and helper functions for the pileup consensus fixer.
// No dependencies; every other file imports this package.
package pcf_pkg;

   localparam int WINDOW_SIZE = 4096;
   localparam int COUNT_BITS  = 16;
   localparam int NUM_CODES   = 6;
   localparam int ADDR_BITS   = $clog2(WINDOW_SIZE);
   localparam int POS_BITS    = 12;
   localparam int CHAR_BITS   = 8;
   localparam int CODE_BITS   = 3;

   localparam logic [CODE_BITS-1:0] CODE_DEL   = 3'd0;
   localparam logic [CODE_BITS-1:0] CODE_A     = 3'd1;
   localparam logic [CODE_BITS-1:0] CODE_C     = 3'd2;
   localparam logic [CODE_BITS-1:0] CODE_G     = 3'd3;
   localparam logic [CODE_BITS-1:0] CODE_T     = 3'd4;
   localparam logic [CODE_BITS-1:0] CODE_OTHER = 3'd5;

   typedef enum logic {
      OP_VOTE    = 1'b0,
      OP_RESOLVE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_FETCH,
      ST_EXEC
   } back_state_type;

   typedef struct packed {
      logic                 operation;
      logic [POS_BITS-1:0]  position;
      logic [CHAR_BITS-1:0] base_char;
   } req_type;

   typedef struct packed {
      logic                 changed;
      logic [POS_BITS-1:0]  fix_position;
      logic [CODE_BITS-1:0] fix_base;
   } rsp_type;

   // Classified request as it travels from the front to the back.
   typedef struct packed {
      op_type               op;
      logic                 in_window;
      logic [POS_BITS-1:0]  position;
      logic [CODE_BITS-1:0] code;
      logic [CHAR_BITS-1:0] ref_char;
   } item_type;

   // One memory row: six vote counters and the touched flag.
   typedef struct packed {
      logic                                 touched;
      logic [NUM_CODES-1:0][COUNT_BITS-1:0] count;
   } row_type;

   typedef struct packed {
      logic clearing;
      logic exec;
   } back_status_type;

   function automatic logic [CODE_BITS-1:0] char_to_code(input logic [CHAR_BITS-1:0] c);
      logic [CODE_BITS-1:0] code;
      case (c) inside
         8'h2E:        code = CODE_DEL;
         8'h41, 8'h61: code = CODE_A;
         8'h43, 8'h63: code = CODE_C;
         8'h47, 8'h67: code = CODE_G;
         8'h54, 8'h74: code = CODE_T;
         default:      code = CODE_OTHER;
      endcase
      return code;
   endfunction

   function automatic logic [CHAR_BITS-1:0] code_to_symbol(input logic [CODE_BITS-1:0] code);
      logic [CHAR_BITS-1:0] sym;
      case (code)
         CODE_DEL: sym = 8'h2E;
         CODE_A:   sym = 8'h41;
         CODE_C:   sym = 8'h43;
         CODE_G:   sym = 8'h47;
         CODE_T:   sym = 8'h54;
         default:  sym = 8'h4E;
      endcase
      return sym;
   endfunction

endpackage

// ----- sv/pcf_front.sv -----
// Front end: accepts requests, maps the character to a vote code and checks the window.
// Depends on pcf_pkg.
module pcf_front import pcf_pkg::*; (
   input  logic     start,
   input  req_type  req_data,
   input  logic     q_full,
   input  logic     clearing,
   output logic     busy,
   output logic     push,
   output item_type push_item
);

   // Hold off requests while the counter memory clears or the queue is full.
   assign busy = clearing | q_full;
   assign push = start & ~busy;

   always_comb begin
      push_item.op        = op_type'(req_data.operation);
      push_item.in_window = (32'(req_data.position) < WINDOW_SIZE);
      push_item.position  = req_data.position;
      push_item.code      = char_to_code(req_data.base_char);
      push_item.ref_char  = req_data.base_char;
   end

endmodule

// ----- sv/pcf_queue.sv -----
// Two-entry queue of classified requests between the front and the back end.
// Depends on pcf_pkg.
module pcf_queue import pcf_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   input  logic     pop,
   output item_type head_item,
   output logic     full,
   output logic     empty
);

   item_type   entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff,  count_in;

   assign full      = (count_ff == 2'd2);
   assign empty     = (count_ff == 2'd0);
   assign head_item = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ----- sv/pcf_back.sv -----
// Back end: clears counter memory after reset, then reads one row per request and may write it.
// Depends on pcf_pkg.
module pcf_back import pcf_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            q_empty,
   input  item_type        head_item,
   output logic            pop,
   output back_status_type status,
   output logic            rsp_valid,
   output rsp_type         rsp_data
);

   row_type mem_ram [WINDOW_SIZE];

   back_state_type         state_ff, state_in;
   logic [ADDR_BITS-1:0]   clr_addr_ff, clr_addr_in;
   item_type               cur_ff, cur_in;
   row_type                rd_row_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   logic                   rd_en;
   logic                   wr_en;
   logic [ADDR_BITS-1:0]   wr_addr;
   row_type                wr_row;
   row_type                vote_row;
   logic [COUNT_BITS-1:0]  vote_cnt;
   logic [CODE_BITS-1:0]   best;
   logic [COUNT_BITS-1:0]  best_cnt;

   // Consensus: strictly greatest of codes A..N, lowest code wins ties.
   always_comb begin
      best     = CODE_A;
      best_cnt = rd_row_ff.count[CODE_A];
      for (int j = 2; j < NUM_CODES; j++) begin
         if (rd_row_ff.count[j] > best_cnt) begin
            best_cnt = rd_row_ff.count[j];
            best     = CODE_BITS'(j);
         end
      end
   end

   // Saturating increment of the voted counter.
   always_comb begin
      vote_row         = rd_row_ff;
      vote_cnt         = rd_row_ff.count[cur_ff.code];
      vote_row.touched = 1'b1;
      if (vote_cnt != '1) begin
         vote_row.count[cur_ff.code] = vote_cnt + 1'b1;
      end
   end

   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      cur_in       = cur_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      pop          = 1'b0;
      rd_en        = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = cur_ff.position[ADDR_BITS-1:0];
      wr_row       = '0;
      case (state_ff)
         ST_CLEAR: begin
            wr_en       = 1'b1;
            wr_addr     = clr_addr_ff;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == ADDR_BITS'(WINDOW_SIZE - 1)) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            if (!q_empty) begin
               pop      = 1'b1;
               rd_en    = 1'b1;
               cur_in   = head_item;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            rsp_valid_in        = 1'b1;
            rsp_in.changed      = 1'b0;
            rsp_in.fix_position = cur_ff.position;
            rsp_in.fix_base     = CODE_DEL;
            if (cur_ff.in_window) begin
               if (cur_ff.op == OP_VOTE) begin
                  wr_en  = 1'b1;
                  wr_row = vote_row;
               end else if (rd_row_ff.touched) begin
                  wr_en           = 1'b1;
                  wr_row          = '0;
                  rsp_in.fix_base = best;
                  rsp_in.changed  = (cur_ff.ref_char != code_to_symbol(best));
               end
            end
            state_in = ST_FETCH;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ram[wr_addr] <= wr_row;
      end
      if (rd_en) begin
         rd_row_ff <= mem_ram[head_item.position[ADDR_BITS-1:0]];
      end
   end

   assign status.clearing = (state_ff == ST_CLEAR);
   assign status.exec     = (state_ff == ST_EXEC);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_ff;

endmodule

// ----- sv/pileup_consensus_fixer_unit.sv -----
// Pileup consensus fixer: per-position vote counters with majority-vote resolve.
// Flow: an accepted request is queued, fetched with its row read into a register, and executed;
// the response is registered. Each read-then-write pass on the RAM ends before the next fetch.
// Reset: synchronous; afterwards busy stays high while the RAM clears one row per cycle.
// The receiver cannot stall: each response is shown for exactly one cycle.
// Depends on pcf_pkg, pcf_front, pcf_queue and pcf_back.
module pileup_consensus_fixer_unit import pcf_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   // Front to queue.
   logic            push;
   item_type        push_item;
   // Queue to back.
   logic            q_full;
   logic            q_empty;
   logic            pop;
   item_type        head_item;
   back_status_type status;

   // Accept and classify requests; stall only on the queue or the clearing pass.
   pcf_front u_front (
      .start     (start),
      .req_data  (req_data),
      .q_full    (q_full),
      .clearing  (status.clearing),
      .busy      (busy),
      .push      (push),
      .push_item (push_item)
   );

   // Decouple acceptance from the RAM update so the front keeps taking requests.
   pcf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .full      (q_full),
      .empty     (q_empty)
   );

   // Read the row, update or resolve it, write it back and register the response.
   pcf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .head_item (head_item),
      .pop       (pop),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTHESIS
   // Never take a request while the RAM is still clearing.
   assert property (@(posedge clock) disable iff (reset) status.clearing |-> busy)
      else $error("request window open during clearing pass");

   // A response strobe is only raised after an execute cycle.
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> $past(status.exec))
      else $error("response without execute cycle");

   // An accepted request is held in the queue on the next cycle.
   assert property (@(posedge clock) disable iff (reset) (start && !busy) |=> !q_empty)
      else $error("accepted request lost before queue");

   // A fix always names a real base.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.changed) |-> (rsp_data.fix_base != CODE_DEL))
      else $error("fix flagged without consensus base");
`endif

endmodule

// ----- test/tb_pileup_consensus_fixer_unit.sv -----
// Self-checking testbench for pileup_consensus_fixer_unit: votes and resolves are
// predicted per position and every fix strobe is compared against the prediction.
// Depends on pcf_pkg and the RTL of pileup_consensus_fixer_unit only.
`timescale 1ns / 1ps

module tb_pileup_consensus_fixer_unit;
   import pcf_pkg::*;

   localparam int IDLE_LIMIT  = 20000;  // covers the clearing pass after reset
   localparam int DRAIN_SLACK = 8;      // extra settling time after the drain
   localparam int RANDOM_ITEMS = 1200;
   localparam int HOT_SPOTS    = 12;

   // Tracks the vote counters per position, predicts the fix for every accepted request
   // and compares each response strobe with the oldest prediction.
   class fix_tracker;
      bit [COUNT_BITS-1:0] votes [WINDOW_SIZE][NUM_CODES];
      bit                  touched [WINDOW_SIZE];
      rsp_type             expected_fixes [$];
      int                  mismatch_count;
      string               alphabet = ".ACGTN";

      function logic [CODE_BITS-1:0] code_of(input logic [CHAR_BITS-1:0] ch);
         logic [CODE_BITS-1:0] code;
         code = CODE_OTHER;
         if (ch == alphabet[CODE_DEL]) code = CODE_DEL;
         for (int c = CODE_A; c <= CODE_T; c++) begin
            // letters match in either case
            if ((ch | 8'h20) == (alphabet[c] | 8'h20)) code = CODE_BITS'(c);
         end
         return code;
      endfunction

      function void note_request(input req_type r);
         rsp_type              fix;
         logic [CODE_BITS-1:0] code;
         logic [CODE_BITS-1:0] best;
         int unsigned          p;
         fix = '0;
         fix.fix_position = r.position;
         p = 32'(r.position);
         if (p < WINDOW_SIZE) begin
            if (r.operation == OP_VOTE) begin
               code = code_of(r.base_char);
               if (votes[p][code] != {COUNT_BITS{1'b1}}) votes[p][code]++;
               touched[p] = 1'b1;
            end else if (touched[p]) begin
               // strictly greatest wins, so the lowest code keeps a tie; deletions never count
               best = CODE_A;
               for (int c = CODE_C; c <= CODE_OTHER; c++) begin
                  if (votes[p][c] > votes[p][best]) best = CODE_BITS'(c);
               end
               fix.fix_base = best;
               fix.changed  = (r.base_char != alphabet[best]);
               for (int c = CODE_DEL; c <= CODE_OTHER; c++) votes[p][c] = '0;
               touched[p] = 1'b0;
            end
         end
         expected_fixes.insert(expected_fixes.size(), fix);
      endfunction

      function void check_fix(input rsp_type got);
         rsp_type want;
         if (expected_fixes.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("%0t: unexpected response changed=%0d pos=%0d base=%0d", $time,
                        got.changed, got.fix_position, got.fix_base);
            return;
         end
         want = expected_fixes.pop_front();
         if (got.changed !== want.changed || got.fix_position !== want.fix_position ||
             got.fix_base !== want.fix_base) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("%0t: mismatch expected changed=%0d pos=%0d base=%0d, got %0d %0d %0d",
                        $time, want.changed, want.fix_position, want.fix_base,
                        got.changed, got.fix_position, got.fix_base);
         end
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   fix_tracker board;
   bit         sender_idles;
   int         quiet_cycles;
   logic [POS_BITS-1:0] hot_spot [HOT_SPOTS];

   pileup_consensus_fixer_unit dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Observe both channels at each rising edge. Inputs change only through nonblocking
   // assignments, so the values read here are the ones the block saw at this edge.
   always @(posedge clock) begin
      if (!reset && start && !busy) board.note_request(req_data);
      if (!reset && rsp_valid) board.check_fix(rsp_data);
      if (!reset && ((start && !busy) || rsp_valid)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Present one request and hold it until the block takes it. Start stays high on
   // return, so back-to-back requests never drop it within one time step.
   task automatic send_request(input req_type r);
      if (sender_idles) begin
         while ($urandom_range(99) < 24) begin
            start <= 1'b0;
            @(posedge clock);
         end
      end
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
   endtask

   task automatic cast_vote(input logic [POS_BITS-1:0] pos, input logic [CHAR_BITS-1:0] ch);
      req_type r;
      r.operation = OP_VOTE;
      r.position  = pos;
      r.base_char = ch;
      send_request(r);
   endtask

   task automatic resolve_at(input logic [POS_BITS-1:0] pos, input logic [CHAR_BITS-1:0] ch);
      req_type r;
      r.operation = OP_RESOLVE;
      r.position  = pos;
      r.base_char = ch;
      send_request(r);
   endtask

   // Hold the sender off until every predicted fix has come back.
   task automatic wait_for_drain();
      start <= 1'b0;
      @(posedge clock);
      while (board.expected_fixes.size() != 0) @(posedge clock);
   endtask

   initial begin
      string vote_chars;
      string ref_chars;
      logic [POS_BITS-1:0]  pos;
      logic [CHAR_BITS-1:0] ch;

      board        = new;
      vote_chars   = "ACGTacgt.N";
      ref_chars    = "ACGTNacgt";
      sender_idles = 1'b1;
      quiet_cycles = 0;
      reset        = 1'b1;
      start        = 1'b0;
      req_data     = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed part. Resolve a position that never got a vote.
      resolve_at(12'd5, "A");
      // Only deletion votes: consensus falls back to A.
      cast_vote(12'd0, ".");
      resolve_at(12'd0, "A");
      // Lower-case votes count; a lower-case reference always differs.
      cast_vote(12'd4095, "a");
      cast_vote(12'd4095, "c");
      cast_vote(12'd4095, "c");
      cast_vote(12'd4095, "g");
      resolve_at(12'd4095, "c");
      // Tie between G and T: the lower code wins.
      cast_vote(12'd7, "G");
      cast_vote(12'd7, "T");
      resolve_at(12'd7, "G");
      // Unknown bytes, including the extremes, count as other.
      cast_vote(12'd9, 8'h00);
      cast_vote(12'd9, 8'hFF);
      cast_vote(12'd9, "N");
      cast_vote(12'd9, "t");
      resolve_at(12'd9, "N");
      // Resolve clears the position, so a second resolve sees nothing.
      resolve_at(12'd9, "N");
      // Deletions outnumber T but are ignored.
      cast_vote(12'd2048, ".");
      cast_vote(12'd2048, ".");
      cast_vote(12'd2048, "T");
      resolve_at(12'd2048, 8'hFF);

      // Pause the sender until the block has answered everything.
      wait_for_drain();

      // Random part: most traffic lands on a few hot positions so that resolves see
      // real pileups; the rest goes anywhere in the window.
      foreach (hot_spot[i]) hot_spot[i] = POS_BITS'($urandom_range(WINDOW_SIZE - 1));
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         // drop idling for a long stretch in the middle
         sender_idles = !(n >= 400 && n < 700);
         if ($urandom_range(99) < 15) pos = POS_BITS'($urandom_range(WINDOW_SIZE - 1));
         else pos = hot_spot[$urandom_range(HOT_SPOTS - 1)];
         if ($urandom_range(99) < 72) begin
            if ($urandom_range(99) < 85) ch = vote_chars[$urandom_range(9)];
            else ch = CHAR_BITS'($urandom_range(255));
            cast_vote(pos, ch);
         end else begin
            if ($urandom_range(99) < 60) ch = ref_chars[$urandom_range(8)];
            else ch = CHAR_BITS'($urandom_range(255));
            resolve_at(pos, ch);
         end
      end

      wait_for_drain();
      repeat (DRAIN_SLACK) @(posedge clock);
      if (board.mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
